>>> sv/assert_macros.svh
// Assertion macros used by the alignment sequencer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TAS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define TAS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

>>> sv/tas_pkg.sv
// Package with the types, codes and constants of the alignment sequencer.
package tas_pkg;

	// Field widths of the stream payloads and the configuration port.
	localparam int COORD_IN_W     = 12;
	localparam int COORD_BITS_DEF = 12;
	localparam int CAL_W          = 64;
	localparam int TOL_W          = 48;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 64;
	localparam int S_TDATA_W      = 48;
	localparam int S_TUSER_W      = 3;
	localparam int M_TDATA_W      = 8;
	localparam int M_TUSER_W      = 2;

	// Fixed numbers of the alignment rules.
	localparam int UNSAFE_LIMIT   = 400;
	localparam int DEFLECT_OFFSET = 1920;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_CAL_VALID = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_N     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_K     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TOL_N     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TOL_K     = 3'd4;

	// Group selector codes.
	localparam logic [1:0] GRP_N = 2'd0;
	localparam logic [1:0] GRP_K = 2'd1;

	typedef enum logic [1:0] {
		PH_DEFLECT = 2'd0,
		PH_ROTATE  = 2'd1,
		PH_SLIDE   = 2'd2,
		PH_RECHECK = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		ACT_NONE    = 3'd0,
		ACT_DEFLECT = 3'd1,
		ACT_ROTATE  = 3'd2,
		ACT_SLIDE   = 3'd3,
		ACT_DONE    = 3'd4
	} act_t;

	typedef enum logic [1:0] {
		DIR_NONE   = 2'd0,
		DIR_EXTEND = 2'd1,
		DIR_SHRINK = 2'd2
	} dir_t;

	// Register file contents as seen by the decision logic.
	typedef struct packed {
		logic               cal_valid;
		logic [CAL_W-1:0]   cal_n;
		logic [CAL_W-1:0]   cal_k;
		logic [TOL_W-1:0]   tol_n;
		logic [TOL_W-1:0]   tol_k;
	} cfg_t;

	// One result item.
	typedef struct packed {
		logic  valid;
		logic  safe;
		act_t  act;
		dir_t  dir;
	} res_t;

	// Outcome of one item: the result and the phase that follows it.
	typedef struct packed {
		res_t   res;
		phase_t next_phase;
	} step_t;

endpackage

>>> sv/three_axis_alignment_sequencer.sv
// Top level of the three-axis alignment sequencer: input and result registers.
//
//  Channel   Direction  Handshake                      Payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  tdata: points, tuser: valid, group
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata: actuator, direction
//  cfg       in         cfg_valid / cfg_ready          cfg_index, cfg_data
//
// Each request is taken into an input register and decided combinationally by the
// window logic. The result register loads the decision once it is free and offers
// it on m_axis. One item is accepted every cycle while results are taken.
// The alignment phase register is updated as the result register loads.
// A stalled result register holds its item; the input register then fills
// and the input side stalls until the result is taken.
// Reset clears the phase, all configuration registers and both valid flags.
`include "assert_macros.svh"

module three_axis_alignment_sequencer #(
	parameter int COORD_BITS = tas_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// point_a_x[11:0], point_a_y[23:12], point_b_x[35:24], point_b_y[47:36]
	input  logic [tas_pkg::S_TDATA_W-1:0]       s_axis_tdata,
	// item_valid[0], group_sel[2:1]
	input  logic [tas_pkg::S_TUSER_W-1:0]       s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// actuator[2:0], direction[4:3], zero fill[7:5]
	output logic [tas_pkg::M_TDATA_W-1:0]       m_axis_tdata,
	// result_valid[0], is_safe[1]
	output logic [tas_pkg::M_TUSER_W-1:0]       m_axis_tuser,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tas_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tas_pkg::CFG_DATA_W-1:0]      cfg_data
);

	// Coordinate bits kept: the low COORD_BITS (at most all 12) of each 12-bit field.
	localparam int CI = tas_pkg::COORD_IN_W;
	localparam int CW = (COORD_BITS < CI) ? COORD_BITS : CI;

	tas_pkg::cfg_t    cfg;
	tas_pkg::step_t   step;
	tas_pkg::phase_t  phase_q;
	tas_pkg::res_t    res_q;
	logic             vld_s1;
	logic             ivld_s1;
	logic [1:0]       grp_s1;
	logic [CW-1:0]    ax_s1, ay_s1, bx_s1, by_s1;
	logic             out_vld_q;
	logic             advance;
	logic             load;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	tas_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Handshake: the input register moves on whenever the result register is free.
	assign advance       = !out_vld_q || m_axis_tready;
	assign s_axis_tready = !vld_s1 || advance;
	assign load          = s_axis_tvalid && s_axis_tready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (load) begin
			vld_s1 <= 1'b1;
		end else if (advance) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ivld_s1 <= s_axis_tuser[0];
			grp_s1  <= s_axis_tuser[2:1];
			ax_s1   <= s_axis_tdata[CW-1:0];
			ay_s1   <= s_axis_tdata[CI+CW-1:CI];
			bx_s1   <= s_axis_tdata[2*CI+CW-1:2*CI];
			by_s1   <= s_axis_tdata[3*CI+CW-1:3*CI];
		end
	end

	tas_align_core #(
		.COORD_W (CW)
	) u_core (
		.phase      (phase_q),
		.item_valid (ivld_s1),
		.group_sel  (grp_s1),
		.ax         (ax_s1),
		.ay         (ay_s1),
		.bx         (bx_s1),
		.by         (by_s1),
		.cfg        (cfg),
		.step       (step)
	);

	// Result register and phase, updated together as an item is decided.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			phase_q   <= tas_pkg::PH_DEFLECT;
		end else if (advance) begin
			out_vld_q <= vld_s1;
			if (vld_s1) begin
				phase_q <= step.next_phase;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && vld_s1) begin
			res_q <= step.res;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {3'b000, res_q.dir, res_q.act};
	assign m_axis_tuser  = {res_q.safe, res_q.valid};

	// A commanded actuator comes only from a valid, safe item.
	`TAS_ASSERT_IMP(a_act_needs_safe, clk, arst_n,
		out_vld_q && (res_q.act != tas_pkg::ACT_NONE), res_q.valid && res_q.safe)
	// The phase moves only when an item passes into the result register.
	`TAS_ASSERT_NXT(a_phase_hold, clk, arst_n,
		!(vld_s1 && advance), $stable(phase_q))
	// An aligned result sends the walk back to the deflect phase.
	`TAS_ASSERT_NXT(a_done_resets, clk, arst_n,
		vld_s1 && advance && (step.res.act == tas_pkg::ACT_DONE),
		phase_q == tas_pkg::PH_DEFLECT)
	// An aligned result carries no direction.
	`TAS_ASSERT_IMP(a_done_nodir, clk, arst_n,
		out_vld_q && (res_q.act == tas_pkg::ACT_DONE), res_q.dir == tas_pkg::DIR_NONE)

endmodule

>>> sv/tas_cfg_regs.sv
// Configuration register file of the alignment sequencer.
module tas_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [tas_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [tas_pkg::CFG_DATA_W-1:0]   wr_data,
	output tas_pkg::cfg_t                    cfg
);

	tas_pkg::cfg_t cfg_q;

	// Write the addressed register; indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				tas_pkg::REG_CAL_VALID: cfg_q.cal_valid <= wr_data[0];
				tas_pkg::REG_CAL_N:     cfg_q.cal_n     <= wr_data[tas_pkg::CAL_W-1:0];
				tas_pkg::REG_CAL_K:     cfg_q.cal_k     <= wr_data[tas_pkg::CAL_W-1:0];
				tas_pkg::REG_TOL_N:     cfg_q.tol_n     <= wr_data[tas_pkg::TOL_W-1:0];
				tas_pkg::REG_TOL_K:     cfg_q.tol_k     <= wr_data[tas_pkg::TOL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> sv/tas_align_core.sv
// Decision logic for one item: safety check and the deflect, rotate, slide walk.
module tas_align_core #(
	parameter int COORD_W = tas_pkg::COORD_BITS_DEF
) (
	input  tas_pkg::phase_t       phase,
	input  logic                  item_valid,
	input  logic [1:0]            group_sel,
	input  logic [COORD_W-1:0]    ax,
	input  logic [COORD_W-1:0]    ay,
	input  logic [COORD_W-1:0]    bx,
	input  logic [COORD_W-1:0]    by,
	input  tas_pkg::cfg_t         cfg,
	output tas_pkg::step_t        step
);

	// Signed width that holds every axis measure plus or minus a tolerance.
	localparam int MW = 20;
	localparam int EW = 18;

	function automatic logic [15:0] abs_diff(input logic [15:0] a, input logic [15:0] b);
		logic signed [16:0] d;
		d = $signed({1'b0, a}) - $signed({1'b0, b});
		abs_diff = d[16] ? 16'(-d) : 16'(d);
	endfunction

	logic                      is_k;
	logic                      usable;
	logic [tas_pkg::CAL_W-1:0] cal;
	logic [tas_pkg::TOL_W-1:0] tw;
	logic [15:0]               rax, ray, rbx, rby;
	logic [15:0]               ax16, ay16, bx16, by16;
	logic [EW-1:0]             err;
	logic                      unsafe;
	logic signed [MW-1:0]      meas [3];
	logic signed [MW-1:0]      refv [3];
	logic signed [MW-1:0]      tol  [3];
	tas_pkg::dir_t             below [3];
	tas_pkg::dir_t             dirs  [3];

	// Pick the group's calibration and widen the coordinates.
	assign is_k   = (group_sel == tas_pkg::GRP_K);
	assign usable = item_valid && cfg.cal_valid &&
	                ((group_sel == tas_pkg::GRP_N) || (group_sel == tas_pkg::GRP_K));
	assign cal    = is_k ? cfg.cal_k : cfg.cal_n;
	assign tw     = is_k ? cfg.tol_k : cfg.tol_n;
	assign rax    = cal[15:0];
	assign ray    = cal[31:16];
	assign rbx    = cal[47:32];
	assign rby    = cal[63:48];
	assign ax16   = 16'(ax);
	assign ay16   = 16'(ay);
	assign bx16   = 16'(bx);
	assign by16   = 16'(by);

	// Summed absolute point error against the calibration points.
	assign err = EW'(abs_diff(rax, ax16)) + EW'(abs_diff(ray, ay16)) +
	             EW'(abs_diff(rbx, bx16)) + EW'(abs_diff(rby, by16));
	assign unsafe = (err > EW'(tas_pkg::UNSAFE_LIMIT));

	// Axis measures, references and the direction to use below the window.
	always_comb begin
		tol[0] = MW'(tw[15:0]);
		tol[1] = MW'(tw[31:16]);
		tol[2] = MW'(tw[47:32]);
		if (is_k) begin
			meas[0]  = MW'(ay16) - MW'(by16);
			refv[0]  = MW'(ray) - MW'(rby);
			meas[1]  = MW'(ax16);
			refv[1]  = MW'(rax);
			meas[2]  = MW'(ay16);
			refv[2]  = MW'(ray);
			below[0] = tas_pkg::DIR_EXTEND;
			below[1] = tas_pkg::DIR_EXTEND;
			below[2] = tas_pkg::DIR_EXTEND;
		end else begin
			meas[0]  = MW'(ax16) + MW'(bx16) - MW'(tas_pkg::DEFLECT_OFFSET);
			refv[0]  = MW'(rax) + MW'(rbx) - MW'(tas_pkg::DEFLECT_OFFSET);
			meas[1]  = MW'(ay16);
			refv[1]  = MW'(ray);
			meas[2]  = MW'(ax16);
			refv[2]  = MW'(rax);
			below[0] = tas_pkg::DIR_SHRINK;
			below[1] = tas_pkg::DIR_EXTEND;
			below[2] = tas_pkg::DIR_SHRINK;
		end
	end

	// Window check of each axis, independent of the others.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (meas[i] < refv[i] - tol[i]) begin
				dirs[i] = below[i];
			end else if (meas[i] > refv[i] + tol[i]) begin
				dirs[i] = (below[i] == tas_pkg::DIR_EXTEND) ? tas_pkg::DIR_SHRINK
				                                            : tas_pkg::DIR_EXTEND;
			end else begin
				dirs[i] = tas_pkg::DIR_NONE;
			end
		end
	end

	// First failing axis from the current phase on, else the re-check from deflect.
	always_comb begin
		logic        hit_walk;
		logic        hit_all;
		logic [1:0]  idx_walk;
		logic [1:0]  idx_all;
		hit_walk = 1'b0;
		hit_all  = 1'b0;
		idx_walk = 2'd0;
		idx_all  = 2'd0;
		for (int i = 0; i < 3; i++) begin
			if (!hit_walk && (2'(i) >= phase) && (dirs[i] != tas_pkg::DIR_NONE)) begin
				hit_walk = 1'b1;
				idx_walk = 2'(i);
			end
			if (!hit_all && (dirs[i] != tas_pkg::DIR_NONE)) begin
				hit_all = 1'b1;
				idx_all = 2'(i);
			end
		end

		step.res        = '0;
		step.next_phase = phase;
		if (usable) begin
			step.res.valid = 1'b1;
			if (!unsafe) begin
				step.res.safe = 1'b1;
				if (hit_walk) begin
					step.res.act    = tas_pkg::act_t'(3'(idx_walk) + 3'd1);
					step.res.dir    = dirs[idx_walk];
					step.next_phase = tas_pkg::phase_t'(idx_walk);
				end else if (hit_all) begin
					step.res.act    = tas_pkg::act_t'(3'(idx_all) + 3'd1);
					step.res.dir    = dirs[idx_all];
					step.next_phase = tas_pkg::PH_RECHECK;
				end else begin
					step.res.act    = tas_pkg::ACT_DONE;
					step.res.dir    = tas_pkg::DIR_NONE;
					step.next_phase = tas_pkg::PH_DEFLECT;
				end
			end
		end
	end

endmodule

>>> sim/tb.sv
// Self-checking testbench for the three-axis alignment sequencer.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_MAX   = (1 << tas_pkg::COORD_IN_W) - 1;
	localparam int FIELD_MAX   = 16'hFFFF;
	localparam int CYCLE_LIMIT = 400000;

	// Group selector codes that name no group.
	localparam logic [1:0] GRP_SPARE_LO = 2'd2;
	localparam logic [1:0] GRP_SPARE_HI = 2'd3;

	// One measurement request as the testbench builds it.
	typedef struct packed {
		logic                           ok;
		logic [1:0]                     grp;
		logic [tas_pkg::COORD_IN_W-1:0] ax;
		logic [tas_pkg::COORD_IN_W-1:0] ay;
		logic [tas_pkg::COORD_IN_W-1:0] bx;
		logic [tas_pkg::COORD_IN_W-1:0] by;
	} sample_t;

	logic                           clk;
	logic                           arst_n;
	logic                           s_axis_tvalid;
	logic                           s_axis_tready;
	logic [tas_pkg::S_TDATA_W-1:0]  s_axis_tdata;
	logic [tas_pkg::S_TUSER_W-1:0]  s_axis_tuser;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	logic [tas_pkg::M_TDATA_W-1:0]  m_axis_tdata;
	logic [tas_pkg::M_TUSER_W-1:0]  m_axis_tuser;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [tas_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [tas_pkg::CFG_DATA_W-1:0] cfg_data;

	// Shadow copy of the registers and the phase, plus the commands still owed.
	tas_pkg::cfg_t   model_cfg;
	tas_pkg::phase_t align_ph;
	tas_pkg::res_t   pending_commands[$];

	int  mismatches = 0;
	int  result_count = 0;
	int  cycles = 0;
	int  stall_left = 0;
	logic calm;

	three_axis_alignment_sequencer u_top (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Run length guard.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Gap length for either side: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(6, 35);
	endfunction

	function automatic logic [tas_pkg::COORD_IN_W-1:0] clamp_coord(input int v);
		if (v < 0)
			return '0;
		if (v > COORD_MAX)
			return '1;
		return v[tas_pkg::COORD_IN_W-1:0];
	endfunction

	function automatic logic [tas_pkg::CAL_W-1:0] pack_points(input int ax, ay, bx, by);
		return {by[15:0], bx[15:0], ay[15:0], ax[15:0]};
	endfunction

	function automatic logic [tas_pkg::TOL_W-1:0] pack_tols(input int dfl, rot, sld);
		return {sld[15:0], rot[15:0], dfl[15:0]};
	endfunction

	// Direction for one axis: none inside the window, else the corrective move.
	function automatic tas_pkg::dir_t window_dir(input int m, input int r, input int t,
			input tas_pkg::dir_t low_dir);
		if (m < r - t)
			return low_dir;
		if (m > r + t)
			return (low_dir == tas_pkg::DIR_EXTEND) ? tas_pkg::DIR_SHRINK : tas_pkg::DIR_EXTEND;
		return tas_pkg::DIR_NONE;
	endfunction

	// Expected command for one request; advances the shadow phase.
	function automatic tas_pkg::res_t predict_command(input sample_t s);
		tas_pkg::res_t             r;
		logic [tas_pkg::CAL_W-1:0] cal;
		logic [tas_pkg::TOL_W-1:0] tw;
		int                        pt[4];
		int                        rp[4];
		int                        tl[3];
		int                        mv[3];
		int                        rv[3];
		tas_pkg::dir_t             lo[3];
		tas_pkg::dir_t             d;
		int                        err;
		int                        diff;
		logic                      is_k;
		r = '0;
		if (!s.ok || !model_cfg.cal_valid || s.grp > tas_pkg::GRP_K)
			return r;
		is_k = (s.grp == tas_pkg::GRP_K);
		cal = is_k ? model_cfg.cal_k : model_cfg.cal_n;
		tw = is_k ? model_cfg.tol_k : model_cfg.tol_n;
		pt[0] = int'(s.ax);
		pt[1] = int'(s.ay);
		pt[2] = int'(s.bx);
		pt[3] = int'(s.by);
		err = 0;
		for (int i = 0; i < 4; i++) begin
			rp[i] = int'(cal[16*i +: 16]);
			diff = pt[i] - rp[i];
			err += (diff < 0) ? -diff : diff;
		end
		r.valid = 1'b1;
		if (err > tas_pkg::UNSAFE_LIMIT)
			return r;
		r.safe = 1'b1;
		for (int i = 0; i < 3; i++)
			tl[i] = int'(tw[16*i +: 16]);
		if (is_k) begin
			mv[0] = pt[1] - pt[3];
			rv[0] = rp[1] - rp[3];
			mv[1] = pt[0];
			rv[1] = rp[0];
			mv[2] = pt[1];
			rv[2] = rp[1];
			lo[0] = tas_pkg::DIR_EXTEND;
			lo[1] = tas_pkg::DIR_EXTEND;
			lo[2] = tas_pkg::DIR_EXTEND;
		end else begin
			mv[0] = pt[0] + pt[2] - tas_pkg::DEFLECT_OFFSET;
			rv[0] = rp[0] + rp[2] - tas_pkg::DEFLECT_OFFSET;
			mv[1] = pt[1];
			rv[1] = rp[1];
			mv[2] = pt[0];
			rv[2] = rp[0];
			lo[0] = tas_pkg::DIR_SHRINK;
			lo[1] = tas_pkg::DIR_EXTEND;
			lo[2] = tas_pkg::DIR_SHRINK;
		end
		// Walk on from the current phase; a passing axis falls through.
		if (align_ph != tas_pkg::PH_RECHECK) begin
			for (int a = int'(align_ph); a < 3; a++) begin
				d = window_dir(mv[a], rv[a], tl[a], lo[a]);
				if (d != tas_pkg::DIR_NONE) begin
					align_ph = tas_pkg::phase_t'(a);
					r.act = tas_pkg::act_t'(a + 1);
					r.dir = d;
					return r;
				end
			end
			align_ph = tas_pkg::PH_RECHECK;
		end
		// Final re-check of every axis.
		for (int a = 0; a < 3; a++) begin
			d = window_dir(mv[a], rv[a], tl[a], lo[a]);
			if (d != tas_pkg::DIR_NONE) begin
				r.act = tas_pkg::act_t'(a + 1);
				r.dir = d;
				return r;
			end
		end
		align_ph = tas_pkg::PH_DEFLECT;
		r.act = tas_pkg::ACT_DONE;
		r.dir = tas_pkg::DIR_NONE;
		return r;
	endfunction

	// Result side: random back-pressure, driven on the falling edge.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_axis_tready = 1'b0;
			stall_left--;
		end else if (calm || $urandom_range(0, 99) < 70) begin
			m_axis_tready = 1'b1;
		end else begin
			m_axis_tready = 1'b0;
			stall_left = pick_gap();
		end
	end

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			mismatches++;
			$display("%0t: result %0d %s mismatch, expected %0d, got %0d",
				$time, result_count, name, want, got);
		end
	endtask

	// Result checker: each accepted command against the oldest prediction.
	always @(posedge clk) begin
		tas_pkg::res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_commands.size() == 0) begin
				mismatches++;
				$display("%0t: result %0d arrived with none expected, tdata %h tuser %h",
					$time, result_count, m_axis_tdata, m_axis_tuser);
			end else begin
				want = pending_commands.pop_front();
				compare_field("result_valid", int'(want.valid), int'(m_axis_tuser[0]));
				compare_field("is_safe", int'(want.safe), int'(m_axis_tuser[1]));
				compare_field("actuator", int'(want.act), int'(m_axis_tdata[2:0]));
				compare_field("direction", int'(want.dir), int'(m_axis_tdata[4:3]));
			end
			result_count++;
		end
	end

	// Sends one request and records its predicted command on acceptance.
	task automatic send_item(input sample_t s);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {s.by, s.bx, s.ay, s.ax};
		s_axis_tuser = {s.grp, s.ok};
		do @(posedge clk); while (!s_axis_tready);
		pending_commands.push_back(predict_command(s));
	endtask

	task automatic send_points(input logic ok, input logic [1:0] grp, input int ax, ay, bx, by);
		sample_t s;
		s.ok = ok;
		s.grp = grp;
		s.ax = clamp_coord(ax);
		s.ay = clamp_coord(ay);
		s.bx = clamp_coord(bx);
		s.by = clamp_coord(by);
		send_item(s);
	endtask

	// Request offset from the group's calibration points.
	task automatic send_near(input logic [1:0] grp, input int dax, day, dbx, dby);
		logic [tas_pkg::CAL_W-1:0] cal;
		cal = (grp == tas_pkg::GRP_K) ? model_cfg.cal_k : model_cfg.cal_n;
		send_points(1'b1, grp, int'(cal[15:0]) + dax, int'(cal[31:16]) + day,
			int'(cal[47:32]) + dbx, int'(cal[63:48]) + dby);
	endtask

	// Waits until every owed command has come and the pipeline is empty.
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (pending_commands.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [tas_pkg::CFG_IDX_W-1:0] idx,
			input logic [tas_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			tas_pkg::REG_CAL_VALID: model_cfg.cal_valid = val[0];
			tas_pkg::REG_CAL_N:     model_cfg.cal_n = val;
			tas_pkg::REG_CAL_K:     model_cfg.cal_k = val;
			tas_pkg::REG_TOL_N:     model_cfg.tol_n = val[tas_pkg::TOL_W-1:0];
			tas_pkg::REG_TOL_K:     model_cfg.tol_k = val[tas_pkg::TOL_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic load_setup(input logic cv, input logic [tas_pkg::CAL_W-1:0] cn, ck,
			input logic [tas_pkg::TOL_W-1:0] tn, tk);
		settle();
		cfg_write(tas_pkg::REG_CAL_VALID, {{(tas_pkg::CFG_DATA_W-1){1'b0}}, cv});
		cfg_write(tas_pkg::REG_CAL_N, cn);
		cfg_write(tas_pkg::REG_CAL_K, ck);
		cfg_write(tas_pkg::REG_TOL_N, {{(tas_pkg::CFG_DATA_W-tas_pkg::TOL_W){1'b0}}, tn});
		cfg_write(tas_pkg::REG_TOL_K, {{(tas_pkg::CFG_DATA_W-tas_pkg::TOL_W){1'b0}}, tk});
	endtask

	// Out of reset nothing is calibrated, so every command is all zeros.
	task automatic test_uncalibrated();
		send_points(1'b1, tas_pkg::GRP_N, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
		send_points(1'b1, tas_pkg::GRP_K, 0, 0, 0, 0);
	endtask

	// Real registers, then writes to unused indexes that must change nothing.
	task automatic test_register_writes();
		load_setup(1'b1, pack_points(1000, 800, 1200, 600), pack_points(2000, 1500, 2100, 1400),
			pack_tols(10, 10, 10), pack_tols(10, 10, 10));
		for (int i = int'(tas_pkg::REG_TOL_K) + 1; i < (1 << tas_pkg::CFG_IDX_W); i++)
			cfg_write(tas_pkg::CFG_IDX_W'(i), '1);
		send_near(tas_pkg::GRP_N, 0, 0, 0, 0);
	endtask

	// Unusable items and unknown groups give all zeros and leave the phase.
	task automatic test_gating();
		send_points(1'b0, tas_pkg::GRP_N, 1000, 800, 1200, 600);
		send_points(1'b1, GRP_SPARE_LO, 1000, 800, 1200, 600);
		send_points(1'b1, GRP_SPARE_HI, 2000, 1500, 2100, 1400);
	endtask

	// Summed error of exactly the limit is safe; one more is not.
	task automatic test_unsafe();
		send_near(tas_pkg::GRP_N, 100, 100, -100, 100);
		send_near(tas_pkg::GRP_N, 100, 100, -100, 101);
	endtask

	// Every group N axis below and above its window, group K cases, fall-through and the re-check.
	task automatic test_phase_walk();
		send_near(tas_pkg::GRP_N, 0, 0, 0, 0);
		send_near(tas_pkg::GRP_N, -20, 0, 0, 0);
		send_near(tas_pkg::GRP_N, 20, 0, 0, 0);
		send_near(tas_pkg::GRP_N, 0, -20, 0, 0);
		send_near(tas_pkg::GRP_N, -20, 0, 20, 0);
		send_near(tas_pkg::GRP_N, 20, 0, -20, 0);
		send_near(tas_pkg::GRP_N, 0, 0, 30, 0);
		send_near(tas_pkg::GRP_N, 0, 30, 0, 0);
		send_near(tas_pkg::GRP_N, 0, 0, 0, 0);
		send_near(tas_pkg::GRP_K, 0, 0, 0, 20);
		send_near(tas_pkg::GRP_K, 0, 0, 0, -20);
		send_near(tas_pkg::GRP_K, -20, 0, 0, 0);
		send_near(tas_pkg::GRP_K, 0, 20, 0, 20);
		send_near(tas_pkg::GRP_K, 0, 0, 0, 0);
	endtask

	// Calibration and tolerance fields at their limits.
	task automatic test_extremes();
		load_setup(1'b1, '1, '0, '0, '1);
		send_points(1'b1, tas_pkg::GRP_N, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
		send_points(1'b1, tas_pkg::GRP_K, 0, 0, 0, 0);
		send_points(1'b1, tas_pkg::GRP_K, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
	endtask

	// Mostly requests close to calibration, so the phase walk completes often.
	task automatic send_random_item();
		sample_t                   s;
		logic [tas_pkg::CAL_W-1:0] cal;
		int                        kind;
		int                        spread;
		int                        pt[4];
		kind = $urandom_range(0, 99);
		s.ok = 1'b1;
		s.grp = 2'($urandom_range(0, 1));
		cal = (s.grp == tas_pkg::GRP_K) ? model_cfg.cal_k : model_cfg.cal_n;
		case ($urandom_range(0, 5))
			0: spread = 0;
			1: spread = 4;
			2: spread = 15;
			3: spread = 40;
			4: spread = 100;
			default: spread = 160;
		endcase
		for (int i = 0; i < 4; i++) begin
			if (kind < 80)
				pt[i] = int'(cal[16*i +: 16]) + int'($urandom_range(0, 2 * spread)) - spread;
			else
				pt[i] = $urandom_range(0, COORD_MAX);
		end
		if (kind >= 88 && kind < 94) begin
			s.ok = 1'b0;
			s.grp = 2'($urandom_range(0, 3));
		end else if (kind >= 94) begin
			s.ok = 1'($urandom_range(0, 1));
			s.grp = 2'($urandom_range(int'(GRP_SPARE_LO), int'(GRP_SPARE_HI)));
		end
		s.ax = clamp_coord(pt[0]);
		s.ay = clamp_coord(pt[1]);
		s.bx = clamp_coord(pt[2]);
		s.by = clamp_coord(pt[3]);
		send_item(s);
	endtask

	function automatic logic [tas_pkg::CAL_W-1:0] random_points(input logic wide);
		int f[4];
		for (int i = 0; i < 4; i++)
			f[i] = wide ? $urandom_range(0, FIELD_MAX) : $urandom_range(0, COORD_MAX);
		return pack_points(f[0], f[1], f[2], f[3]);
	endfunction

	function automatic logic [tas_pkg::TOL_W-1:0] random_tols(input int style);
		int f[3];
		for (int i = 0; i < 3; i++)
			case (style)
				0: f[i] = 0;
				1: f[i] = FIELD_MAX;
				default: f[i] = $urandom_range(0, 48);
			endcase
		return pack_tols(f[0], f[1], f[2]);
	endfunction

	// Random traffic over a series of register settings.
	task automatic test_random_traffic();
		for (int setting = 0; setting < 10; setting++) begin
			load_setup(setting != 7, random_points(setting == 8), random_points(setting == 8),
				random_tols(setting == 0 ? 0 : (setting == 5 ? 1 : 2)),
				random_tols(setting == 0 ? 0 : (setting == 4 ? 1 : 2)));
			calm = (setting % 3 == 2);
			for (int n = 0; n < 115; n++)
				send_random_item();
			calm = 1'b0;
		end
	endtask

	// Main sequence.
	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		model_cfg = '0;
		align_ph = tas_pkg::PH_DEFLECT;
		calm = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		test_uncalibrated();
		test_register_writes();
		test_gating();
		test_unsafe();
		test_phase_walk();
		test_extremes();
		test_random_traffic();
		settle();

		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> files.f
+incdir+sv
sv/tas_pkg.sv
sv/tas_cfg_regs.sv
sv/tas_align_core.sv
sv/three_axis_alignment_sequencer.sv
sim/tb.sv
